// File: rtl/core/bb3ea_pkg.sv
// Shared types, constants and helper functions for the 3x3 edge-aware box blur.
// Used by box_blur_3x3_edge_aware and its bench; depends on nothing else.
`default_nettype none

package bb3ea_pkg;

    // Frame size limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int FRAME_SIZE_RESET = 1024;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Size registers hold 1..MAX, position counters 0..MAX-1
    localparam int FW_W  = $clog2(MAX_WIDTH + 1);
    localparam int FH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Pixel layout
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int PIX_W    = CHAN_W * NUM_CHAN;
    localparam int LINE_W   = 2 * PIX_W;  // {upper row, middle row}

    // Window sum and reciprocal divide
    localparam int SUM_W     = 12;   // 9 * 255 fits
    localparam int CNT_W     = 4;
    localparam int CNT_MAX   = 9;
    localparam int DIV_SHIFT = 16;
    localparam int RECIP_W   = 17;
    localparam int PROD_W    = SUM_W + RECIP_W;

    // Item kind carried on tuser
    localparam logic FUNC_DRAIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    // Input row position, saturating once two rows are in
    typedef enum logic [1:0] {
        ROW_FIRST  = 2'd0,
        ROW_SECOND = 2'd1,
        ROW_LATER  = 2'd2
    } row_phase_t;

    // Per-item window control, decided at input transfer
    typedef struct packed {
        logic started;    // item releases an output pixel
        logic frame_end;  // that pixel closes the frame
        logic row_lo;     // row above is in frame
        logic row_hi;     // row below is in frame
        logic col_lo;     // column left is in frame
        logic col_hi;     // column right is in frame and present
    } win_ctl_t;

    function automatic logic [FW_W-1:0] clamp_width(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) begin
            return FW_W'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            return FW_W'(MAX_WIDTH);
        end else begin
            return FW_W'(v);
        end
    endfunction

    function automatic logic [FH_W-1:0] clamp_height(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) begin
            return FH_W'(1);
        end else if (int'(v) > MAX_HEIGHT) begin
            return FH_W'(MAX_HEIGHT);
        end else begin
            return FH_W'(v);
        end
    endfunction

    // ceil(2^16 / n): exact truncating divide for sums up to 9 * 255
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/box_blur_3x3_edge_aware.sv
// Pipeline: the item that releases a result is registered in stage A, stage B and then the output register;
// pixel data lags the stream by frame_width + 1 items (drain items flush the tail).
// Throughput: one item per clock; the only stall is back-pressure on the m_ side.
// Line buffers: one 48-bit x MAX_WIDTH RAM read and written once per item.
// Reset (aresetn low, synchronous): frame restarts, window cleared, size 1024 x 1024;
// line buffer contents are not cleared and need no clearing pass.
// Depends on bb3ea_pkg and bb3ea_ram.
`default_nettype none

module box_blur_3x3_edge_aware (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,     // pixel_red, pixel_green, pixel_blue
    input  wire logic        s_tuser,     // func
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,     // blur_red, blur_green, blur_blue
    output logic             m_tlast,     // frame_end
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);

    localparam int FW_W     = bb3ea_pkg::FW_W;
    localparam int FH_W     = bb3ea_pkg::FH_W;
    localparam int COL_W    = bb3ea_pkg::COL_W;
    localparam int ROW_W    = bb3ea_pkg::ROW_W;
    localparam int PIX_W    = bb3ea_pkg::PIX_W;
    localparam int LINE_W   = bb3ea_pkg::LINE_W;
    localparam int CHAN_W   = bb3ea_pkg::CHAN_W;
    localparam int NUM_CHAN = bb3ea_pkg::NUM_CHAN;
    localparam int SUM_W    = bb3ea_pkg::SUM_W;
    localparam int CNT_W    = bb3ea_pkg::CNT_W;
    localparam int PROD_W   = bb3ea_pkg::PROD_W;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic en;
    logic accept;
    logic m_tvalid_reg;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign accept    = s_tvalid && en;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Frame size and position counters (front end)
    // ------------------------------------------------------------------
    logic [FW_W-1:0]         fw_reg, fw_next;
    logic [FH_W-1:0]         fh_reg, fh_next;
    logic [COL_W-1:0]        in_col_reg, in_col_next;
    bb3ea_pkg::row_phase_t   in_row_reg, in_row_next;
    bb3ea_pkg::row_phase_t   row_phase_inc;
    logic [COL_W-1:0]        out_col_reg, out_col_next;
    logic [ROW_W-1:0]        out_row_reg, out_row_next;

    logic                    in_col_last;
    logic                    out_col_last;
    logic                    out_row_last;
    bb3ea_pkg::win_ctl_t     ctl_in;
    logic [PIX_W-1:0]        pix_in;

    // Window control for the item now on the input
    always_comb begin
        in_col_last  = (FW_W'(in_col_reg) + FW_W'(1)) >= fw_reg;
        out_col_last = (FW_W'(out_col_reg) + FW_W'(1)) >= fw_reg;
        out_row_last = (FH_W'(out_row_reg) + FH_W'(1)) >= fh_reg;

        ctl_in.started   = (in_row_reg == bb3ea_pkg::ROW_LATER) ||
                           ((in_row_reg == bb3ea_pkg::ROW_SECOND) && (in_col_reg != '0));
        ctl_in.frame_end = ctl_in.started && out_row_last && out_col_last;
        ctl_in.row_lo    = (out_row_reg != '0);
        ctl_in.row_hi    = !out_row_last;
        ctl_in.col_lo    = (out_col_reg != '0);
        // at a row start the newest column belongs to the next row
        ctl_in.col_hi    = !out_col_last && (in_col_reg != '0);

        pix_in = (s_tuser == bb3ea_pkg::FUNC_DRAIN) ? '0 : s_tdata;
    end

    // Saturating row phase step
    always_comb begin
        unique case (in_row_reg)
            bb3ea_pkg::ROW_FIRST:  row_phase_inc = bb3ea_pkg::ROW_SECOND;
            bb3ea_pkg::ROW_SECOND: row_phase_inc = bb3ea_pkg::ROW_LATER;
            bb3ea_pkg::ROW_LATER:  row_phase_inc = bb3ea_pkg::ROW_LATER;
            default:               row_phase_inc = bb3ea_pkg::ROW_FIRST;
        endcase
    end

    // Counter and size updates
    always_comb begin
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (accept) begin
            if (ctl_in.frame_end) begin
                in_col_next  = '0;
                in_row_next  = bb3ea_pkg::ROW_FIRST;
                out_col_next = '0;
                out_row_next = '0;
            end else begin
                if (in_col_last) begin
                    in_col_next = '0;
                    in_row_next = row_phase_inc;
                end else begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                if (ctl_in.started) begin
                    if (out_col_last) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end else begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
            end
        end

        // a frame width or height register write restarts the frame
        if (cfg_valid) begin
            unique case (bb3ea_pkg::cfg_reg_t'(cfg_index))
                bb3ea_pkg::REG_FRAME_WIDTH: begin
                    fw_next      = bb3ea_pkg::clamp_width(cfg_data);
                    in_col_next  = '0;
                    in_row_next  = bb3ea_pkg::ROW_FIRST;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                bb3ea_pkg::REG_FRAME_HEIGHT: begin
                    fh_next      = bb3ea_pkg::clamp_height(cfg_data);
                    in_col_next  = '0;
                    in_row_next  = bb3ea_pkg::ROW_FIRST;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg      <= bb3ea_pkg::clamp_width(
                               bb3ea_pkg::CFG_DATA_W'(bb3ea_pkg::FRAME_SIZE_RESET));
            fh_reg      <= bb3ea_pkg::clamp_height(
                               bb3ea_pkg::CFG_DATA_W'(bb3ea_pkg::FRAME_SIZE_RESET));
            in_col_reg  <= '0;
            in_row_reg  <= bb3ea_pkg::ROW_FIRST;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: accepted item, line buffer read in flight
    // ------------------------------------------------------------------
    logic                a_valid_reg;
    bb3ea_pkg::win_ctl_t a_ctl_reg;
    logic [COL_W-1:0]    a_col_reg;
    logic [PIX_W-1:0]    a_pix_reg;
    logic                fwd_reg;
    logic [LINE_W-1:0]   fwd_data_reg;

    logic [LINE_W-1:0]   ram_rdata;
    logic [LINE_W-1:0]   line_word;
    logic [PIX_W-1:0]    up_pix;
    logic [PIX_W-1:0]    mid_pix;
    logic [LINE_W-1:0]   line_wr_data;
    logic                line_wr_en;
    logic                fwd_next;

    // Line buffers: word at column c holds {row two back, row one back}
    bb3ea_ram #(
        .WIDTH (LINE_W),
        .DEPTH (bb3ea_pkg::MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (line_wr_en),
        .wr_addr (a_col_reg),
        .wr_data (line_wr_data),
        .rd_en   (en),
        .rd_addr (in_col_reg),
        .rd_data (ram_rdata)
    );

    // Bypass the write that collides with the read issued at the same edge
    always_comb begin
        line_word    = fwd_reg ? fwd_data_reg : ram_rdata;
        up_pix       = line_word[LINE_W-1:PIX_W];
        mid_pix      = line_word[PIX_W-1:0];
        line_wr_data = {mid_pix, a_pix_reg};
        line_wr_en   = en && a_valid_reg;
        fwd_next     = accept && a_valid_reg && (in_col_reg == a_col_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end else if (en) begin
            a_valid_reg <= accept;
            fwd_reg     <= fwd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_ctl_reg    <= ctl_in;
            a_col_reg    <= in_col_reg;
            a_pix_reg    <= pix_in;
            fwd_data_reg <= line_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Window columns and masked sums
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] w1_reg [3];   // two columns back
    logic [PIX_W-1:0] w2_reg [3];   // one column back
    logic [PIX_W-1:0] new_col [3];  // rows: upper, middle, incoming
    logic [PIX_W-1:0] tap [3][3];   // [row][column]
    logic [2:0]       row_en;
    logic [2:0]       col_en;
    logic [1:0]       row_cnt;
    logic [1:0]       col_cnt;
    logic [SUM_W-1:0] sum_next [NUM_CHAN];
    logic [CNT_W-1:0] cnt_next;

    always_comb begin
        new_col[0] = up_pix;
        new_col[1] = mid_pix;
        new_col[2] = a_pix_reg;
        for (int r = 0; r < 3; r++) begin
            tap[r][0] = w1_reg[r];
            tap[r][1] = w2_reg[r];
            tap[r][2] = new_col[r];
        end

        row_en = {a_ctl_reg.row_hi, 1'b1, a_ctl_reg.row_lo};
        col_en = {a_ctl_reg.col_hi, 1'b1, a_ctl_reg.col_lo};

        // per-channel sum over in-frame neighbors
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            sum_next[ch] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (row_en[r] && col_en[c]) begin
                        sum_next[ch] = sum_next[ch] +
                                       SUM_W'(tap[r][c][ch*CHAN_W +: CHAN_W]);
                    end
                end
            end
        end

        row_cnt  = 2'd1 + 2'(a_ctl_reg.row_lo) + 2'(a_ctl_reg.row_hi);
        col_cnt  = 2'd1 + 2'(a_ctl_reg.col_lo) + 2'(a_ctl_reg.col_hi);
        cnt_next = CNT_W'(row_cnt) * CNT_W'(col_cnt);
    end

    // Shift the window by one column per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                w1_reg[r] <= '0;
                w2_reg[r] <= '0;
            end
        end else if (en && a_valid_reg) begin
            for (int r = 0; r < 3; r++) begin
                w1_reg[r] <= w2_reg[r];
                w2_reg[r] <= new_col[r];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: sums and divisor
    // ------------------------------------------------------------------
    logic             b_valid_reg;
    logic             b_last_reg;
    logic [SUM_W-1:0] b_sum_reg [NUM_CHAN];
    logic [CNT_W-1:0] b_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg && a_ctl_reg.started;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_last_reg <= a_ctl_reg.frame_end;
            b_cnt_reg  <= cnt_next;
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
                b_sum_reg[ch] <= sum_next[ch];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divide by reciprocal multiply into the output register
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] prod [NUM_CHAN];
    logic [PIX_W-1:0]  mean_pix;
    logic [PIX_W-1:0]  m_data_reg;
    logic              m_last_reg;

    always_comb begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            prod[ch] = PROD_W'(b_sum_reg[ch]) * PROD_W'(bb3ea_pkg::recip(b_cnt_reg));
            mean_pix[ch*CHAN_W +: CHAN_W] = prod[ch][bb3ea_pkg::DIV_SHIFT +: CHAN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= mean_pix;
            m_last_reg <= b_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (FW_W'(in_col_reg) < fw_reg) && (FW_W'(out_col_reg) < fw_reg) &&
        (FH_W'(out_row_reg) < fh_reg))
        else $error("position counter outside the frame");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> ($stable(a_valid_reg) && $stable(b_valid_reg)))
        else $error("pipeline moved while the output was stalled");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> ((b_cnt_reg != '0) && (b_cnt_reg <= CNT_W'(bb3ea_pkg::CNT_MAX))))
        else $error("neighbor count out of range");

    a_fwd_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> a_valid_reg)
        else $error("line buffer bypass without an item in stage A");

endmodule

`default_nettype wire

// File: rtl/core/bb3ea_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
`default_nettype none

module bb3ea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        aclk,
    input  wire logic                                        wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                            wr_data,
    input  wire logic                                        rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, and read port returning the old contents on a collision
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: bench/box_blur_3x3_edge_aware_tb.sv
// Self-checking bench for box_blur_3x3_edge_aware: streams frames of RGB pixels,
// predicts every blurred pixel in a behavioral model and compares on the m_ side.
// Depends on bb3ea_pkg and the box_blur_3x3_edge_aware RTL.
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware_tb;
    import bb3ea_pkg::*;

    localparam logic       FUNC_PIXEL   = ~FUNC_DRAIN;
    localparam logic [1:0] REG_SPARE_A  = 2'd2;
    localparam logic [1:0] REG_SPARE_B  = 2'd3;
    localparam int         IDLE_PCT     = 18;
    localparam int         SETTLE       = 8;     // lets the block's pipeline drain, plus margin
    localparam int         STALL_LIMIT  = 2000;
    localparam int         RANDOM_ITEMS = 1600;
    localparam int         PRINT_CAP    = 40;

    typedef struct packed {
        logic [23:0] rgb;    // red in the low byte
        logic        last;
    } blur_result_t;

    // DUT connections, all inputs known from time zero
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data  = '0;

    // Blur model state
    logic [23:0]            upper_row  [0:MAX_WIDTH-1];
    logic [23:0]            middle_row [0:MAX_WIDTH-1];
    logic [2:0][2:0][23:0]  win;               // [column][row], column 2 newest
    int                     in_r, in_c, out_r, out_c;
    int                     width_cfg  = FRAME_SIZE_RESET;
    int                     height_cfg = FRAME_SIZE_RESET;
    blur_result_t           expected_blur [$];

    // Bookkeeping
    bit    steady_mode = 1'b0;
    int    errors       = 0;
    int    items_sent   = 0;
    int    results_seen = 0;
    int    frames_sent  = 0;
    int    size_writes  = 0;
    string chan_label [3] = '{"red", "green", "blue"};

    box_blur_3x3_edge_aware dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result-side back-pressure
    always @(negedge aclk) begin
        m_tready <= steady_mode || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic int clamp_dim(input logic [10:0] v, input int max_dim);
        if (v == '0) return 1;
        if (int'(v) > max_dim) return max_dim;
        return int'(v);
    endfunction

    function automatic logic [23:0] random_pixel();
        logic [23:0] v;
        int ch;
        v = $urandom;
        // sometimes force each channel to a rail
        if ($urandom_range(0, 7) == 0) begin
            for (ch = 0; ch < 3; ch++) begin
                v[8*ch +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
        end
        return v;
    endfunction

    // Advance the model by one accepted item; queue the pixel it releases, if any
    task automatic predict_blur(input logic func, input logic [23:0] pix);
        logic [23:0]           px, up, mid, p;
        logic [2:0][2:0][23:0] prev;
        int                    sum [3];
        int                    cnt, base, k, rr, cc, c, r, dx, dy, ch;
        bit                    started;
        blur_result_t          res;
        c = in_c;
        r = in_r;
        started = (r > 1) || (r == 1 && c >= 1);
        px = (func == FUNC_DRAIN) ? 24'h0 : pix;
        prev = win;

        // line buffers and window shift
        up  = upper_row[c];
        mid = middle_row[c];
        upper_row[c]  = mid;
        middle_row[c] = px;
        win[0] = win[1];
        win[1] = win[2];
        win[2][0] = up;
        win[2][1] = mid;
        win[2][2] = px;

        if (c + 1 >= width_cfg) begin
            in_c = 0;
            in_r = r + 1;
        end else begin
            in_c = c + 1;
        end
        if (!started) return;

        // at a row start the output pixel's columns sit in the pre-shift window
        base = (c == 0) ? 2 : 1;
        sum = '{0, 0, 0};
        cnt = 0;
        for (dy = -1; dy <= 1; dy++) begin
            rr = out_r + dy;
            if (rr < 0 || rr >= height_cfg) continue;
            for (dx = -1; dx <= 1; dx++) begin
                cc = out_c + dx;
                k = base + dx;
                if (cc < 0 || cc >= width_cfg || k > 2) continue;
                p = (c == 0) ? prev[k][1+dy] : win[k][1+dy];
                for (ch = 0; ch < 3; ch++) begin
                    sum[ch] += p[8*ch +: 8];
                end
                cnt++;
            end
        end
        if (cnt == 0) cnt = 1;
        for (ch = 0; ch < 3; ch++) begin
            res.rgb[8*ch +: 8] = 8'(sum[ch] / cnt);
        end

        if (out_r + 1 >= height_cfg && out_c + 1 >= width_cfg) begin
            res.last = 1'b1;
            in_r = 0;
            in_c = 0;
            out_r = 0;
            out_c = 0;
        end else begin
            res.last = 1'b0;
            if (out_c + 1 >= width_cfg) begin
                out_c = 0;
                out_r++;
            end else begin
                out_c++;
            end
        end
        expected_blur.push_back(res);
    endtask

    // One s_ transfer; entered and left at a falling edge
    task automatic send_item(input logic func, input logic [23:0] pix);
        cfg_valid <= 1'b0;
        while (!steady_mode && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_blur(func, pix);
        items_sent++;
        @(negedge aclk);
    endtask

    // One configuration transfer; the model restarts the frame on a known index
    task automatic write_size_reg(input logic [1:0] idx, input logic [10:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
            if (idx == REG_FRAME_WIDTH) width_cfg = clamp_dim(value, MAX_WIDTH);
            else height_cfg = clamp_dim(value, MAX_HEIGHT);
            in_r = 0;
            in_c = 0;
            out_r = 0;
            out_c = 0;
        end
        size_writes++;
        @(negedge aclk);
    endtask

    // Stop sending, let every expected pixel out, then let the pipe settle
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (expected_blur.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Full frame: pixels then width + 1 drains; noise swaps the item kind now and then
    task automatic stream_frame(input int noise_pct);
        int i;
        for (i = 0; i < width_cfg * height_cfg; i++) begin
            send_item(($urandom_range(0, 99) < noise_pct) ? FUNC_DRAIN : FUNC_PIXEL,
                      random_pixel());
        end
        for (i = 0; i <= width_cfg; i++) begin
            send_item(($urandom_range(0, 99) < 3 * noise_pct) ? FUNC_PIXEL : FUNC_DRAIN,
                      random_pixel());
        end
        frames_sent++;
    endtask

    // Reset size 1024 x 1024: a partial frame, cut off later by a size write
    task automatic test_reset_size();
        int i;
        for (i = 0; i < MAX_WIDTH + 6; i++) begin
            send_item(FUNC_PIXEL, random_pixel());
        end
        wait_quiet();
    endtask

    // Zero sizes clamp to 1 x 1; two frames back to back
    task automatic test_one_pixel_frames();
        write_size_reg(REG_FRAME_WIDTH, 11'd0);
        write_size_reg(REG_FRAME_HEIGHT, 11'd0);
        send_item(FUNC_PIXEL, 24'hFF00FF);
        send_item(FUNC_DRAIN, 24'h000000);
        send_item(FUNC_DRAIN, 24'hFFFFFF);
        send_item(FUNC_PIXEL, 24'h00FF00);
        send_item(FUNC_DRAIN, 24'h000000);
        send_item(FUNC_DRAIN, 24'h000000);
        frames_sent += 2;
        wait_quiet();
    endtask

    // 3 x 3 checkerboard of rails: corner, edge and interior divisors;
    // the center comes in as a drain, and one drain slot carries a pixel
    task automatic test_checker_3x3();
        int i;
        write_size_reg(REG_FRAME_WIDTH, 11'd3);
        write_size_reg(REG_FRAME_HEIGHT, 11'd3);
        for (i = 0; i < 9; i++) begin
            send_item((i == 4) ? FUNC_DRAIN : FUNC_PIXEL, (i % 2 == 0) ? 24'hFFFFFF : 24'h0);
        end
        for (i = 0; i < 4; i++) begin
            send_item((i == 1) ? FUNC_PIXEL : FUNC_DRAIN, 24'hFFFFFF);
        end
        frames_sent++;
        wait_quiet();
    endtask

    // Oversized width clamps to the maximum; a single row
    task automatic test_widest_row();
        write_size_reg(REG_FRAME_WIDTH, 11'h7FF);
        write_size_reg(REG_FRAME_HEIGHT, 11'd1);
        stream_frame(0);
        wait_quiet();
    endtask

    // Oversized height clamps to the maximum; a single column
    task automatic test_tallest_column();
        write_size_reg(REG_FRAME_HEIGHT, 11'h7FF);
        write_size_reg(REG_FRAME_WIDTH, 11'd1);
        stream_frame(0);
        wait_quiet();
    endtask

    // Random sizes; mostly clean frames, some noisy, some cut short
    task automatic test_random_frames();
        int          group, nframes, f, kind, i, start;
        logic [10:0] w_raw, h_raw;
        group = 0;
        start = items_sent;
        while (items_sent < start + RANDOM_ITEMS) begin
            wait_quiet();
            case ($urandom_range(0, 19))
                0:       w_raw = 11'd0;
                1:       w_raw = 11'($urandom_range(13, 64));
                default: w_raw = 11'($urandom_range(1, 12));
            endcase
            h_raw = ($urandom_range(0, 19) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
            if ($urandom_range(0, 7) == 0) begin
                write_size_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 11'($urandom));
            end
            if ($urandom_range(0, 1)) begin
                write_size_reg(REG_FRAME_WIDTH, w_raw);
                write_size_reg(REG_FRAME_HEIGHT, h_raw);
            end else begin
                write_size_reg(REG_FRAME_HEIGHT, h_raw);
                write_size_reg(REG_FRAME_WIDTH, w_raw);
            end

            // one group runs with no idling on either side
            steady_mode = (group == 3);
            nframes = steady_mode ? 3 : $urandom_range(1, 3);
            for (f = 0; f < nframes; f++) begin
                kind = $urandom_range(0, 99);
                if (kind < 80) begin
                    stream_frame(0);
                end else if (kind < 92) begin
                    stream_frame(6);
                end else begin
                    // broken frame: random kinds, stops short; next size write restarts
                    for (i = $urandom_range(1, width_cfg * height_cfg + width_cfg); i > 0; i--) begin
                        send_item(FUNC_PIXEL ^ $urandom_range(0, 1), random_pixel());
                    end
                    break;
                end
            end
            steady_mode = 1'b0;
            group++;
        end
        wait_quiet();
    endtask

    // Compare each result transfer with the oldest predicted pixel
    always @(posedge aclk) begin : check_results
        blur_result_t want;
        int ch;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_blur.size() == 0) begin
                errors++;
                if (errors <= PRINT_CAP) begin
                    $display("%0t: unexpected result: expected none, actual rgb=%h last=%b",
                             $time, m_tdata, m_tlast);
                end
            end else begin
                want = expected_blur.pop_front();
                for (ch = 0; ch < 3; ch++) begin
                    if (m_tdata[8*ch +: 8] !== want.rgb[8*ch +: 8]) begin
                        errors++;
                        if (errors <= PRINT_CAP) begin
                            $display("%0t: %s mismatch: expected %0d, actual %0d", $time,
                                     chan_label[ch], want.rgb[8*ch +: 8], m_tdata[8*ch +: 8]);
                        end
                    end
                end
                if (m_tlast !== want.last) begin
                    errors++;
                    if (errors <= PRINT_CAP) begin
                        $display("%0t: frame_end mismatch: expected %b, actual %b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: timeout, %0d cycles without a transfer", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Test sequence
    initial begin : main_flow
        int i;
        for (i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        win = '0;
        in_r = 0;
        in_c = 0;
        out_r = 0;
        out_c = 0;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_size();
        test_one_pixel_frames();
        test_checker_3x3();
        test_widest_row();
        test_tallest_column();
        test_random_frames();
        wait_quiet();

        $display("Sent %0d items in %0d frames with %0d register writes; checked %0d pixels.",
                 items_sent, frames_sent, size_writes, results_seen);
        $display("Sizes ran from 1x1 to full width and full height, with noisy and cut frames.");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
